// ===== design/cgse_pkg.sv =====
// ----------------------------------------------------------------------------
// cgse_pkg: shared types, register indexes and saturation helpers
// Q16.16 word type, configuration register codes and the clamps used by the
// constant-gain state estimator datapath.
// ----------------------------------------------------------------------------
package cgse_pkg;

    localparam int unsigned DataW    = 32;
    localparam int unsigned StepW    = 24;
    localparam int unsigned InvMassW = 31;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned ProdW    = 2 * DataW;
    localparam int unsigned FracW    = 16;

    typedef logic signed [DataW-1:0] t_q16;
    typedef logic signed [DataW+1:0] t_sum;
    typedef logic signed [ProdW-1:0] t_prod;

    typedef enum logic [CfgIdxW-1:0] {
        REG_GAIN_POSITION    = 3'd0,
        REG_GAIN_VELOCITY    = 3'd1,
        REG_GAIN_ACCEL       = 3'd2,
        REG_GAIN_MOTOR_FORCE = 3'd3,
        REG_GAIN_DRAG_FORCE  = 3'd4,
        REG_GAIN_RPM         = 3'd5,
        REG_INV_MASS         = 3'd6,
        REG_SPEED_TO_RPM     = 3'd7
    } t_reg_idx;

    localparam t_q16                 QMax         = 32'sh7FFF_FFFF;
    localparam t_q16                 QMin         = 32'sh8000_0000;
    localparam logic [InvMassW-1:0]  InvMassReset = 31'd65536;
    localparam t_q16                 SpeedToRpmReset = 32'sd65536;

    // Clamp a wide sum or difference into the signed 32-bit range.
    function automatic t_q16 sat_sum(input t_sum v);
        t_q16 res;
        if ((v[DataW+1:DataW-1] == 3'b000) || (v[DataW+1:DataW-1] == 3'b111)) begin
            res = v[DataW-1:0];
        end else if (v[DataW+1]) begin
            res = QMin;
        end else begin
            res = QMax;
        end
        return res;
    endfunction

    // Scale a full product by 2^-16 (floor) and clamp to 32 bits.
    function automatic t_q16 sat_prod(input t_prod p);
        t_prod s;
        t_q16  res;
        s = p >>> FracW;
        if (s[ProdW-1:DataW-1] == {(ProdW-DataW+1){s[DataW-1]}}) begin
            res = s[DataW-1:0];
        end else if (s[ProdW-1]) begin
            res = QMin;
        end else begin
            res = QMax;
        end
        return res;
    endfunction

endpackage

// ===== design/cgse_in_if.sv =====
// ----------------------------------------------------------------------------
// cgse_in_if: measurement item channel
// Valid/ready channel carrying one time step and six measurements.
// ----------------------------------------------------------------------------
interface cgse_in_if;
    logic                                valid;
    logic                                ready;
    logic [cgse_pkg::StepW-1:0]          time_step;
    logic signed [cgse_pkg::DataW-1:0]   meas_position;
    logic signed [cgse_pkg::DataW-1:0]   meas_velocity;
    logic signed [cgse_pkg::DataW-1:0]   meas_accel;
    logic signed [cgse_pkg::DataW-1:0]   meas_motor_force;
    logic signed [cgse_pkg::DataW-1:0]   meas_drag_force;
    logic signed [cgse_pkg::DataW-1:0]   meas_rpm;

    modport source (
        output valid, time_step, meas_position, meas_velocity, meas_accel,
               meas_motor_force, meas_drag_force, meas_rpm,
        input  ready
    );
    modport sink (
        input  valid, time_step, meas_position, meas_velocity, meas_accel,
               meas_motor_force, meas_drag_force, meas_rpm,
        output ready
    );
endinterface

// ===== design/cgse_out_if.sv =====
// ----------------------------------------------------------------------------
// cgse_out_if: estimate item channel
// Valid/ready channel carrying the six updated estimates.
// ----------------------------------------------------------------------------
interface cgse_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [cgse_pkg::DataW-1:0]   out_position;
    logic signed [cgse_pkg::DataW-1:0]   out_velocity;
    logic signed [cgse_pkg::DataW-1:0]   out_accel;
    logic signed [cgse_pkg::DataW-1:0]   out_motor_force;
    logic signed [cgse_pkg::DataW-1:0]   out_drag_force;
    logic signed [cgse_pkg::DataW-1:0]   out_rpm;

    modport source (
        output valid, out_position, out_velocity, out_accel, out_motor_force,
               out_drag_force, out_rpm,
        input  ready
    );
    modport sink (
        input  valid, out_position, out_velocity, out_accel, out_motor_force,
               out_drag_force, out_rpm,
        output ready
    );
endinterface

// ===== design/constant_gain_state_estimator_core.sv =====
// ----------------------------------------------------------------------------
// constant_gain_state_estimator_core: constant-gain six-state tracker
// Propagates position, velocity and rpm over the time step, acceleration from the
// forces, and corrects every estimate toward its measurement by a fixed Q16.16 gain.
// ----------------------------------------------------------------------------
// Sequence: after the item is taken, the sequencer runs S_VDT to S_URPM,
//   then shows the result item; it takes no new item until the sink takes it.
// Throughput is set by the single shared 32x32 multiplier and the single
//   saturating adder, each used at most once per sequencer step.
// Reset (synchronous, active low): estimates clear to zero, gains clear to
//   zero, inv_mass and speed_to_rpm load 1.0; the block comes up ready.
module constant_gain_state_estimator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cgse_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [cgse_pkg::DataW-1:0]    i_cfg_data,
    cgse_in_if.sink                       i_meas,
    cgse_out_if.source                    o_est
);

    // Sequencer steps. Each step issues at most one multiply and one
    // saturating add; the product of a step is consumed in the next one.
    typedef enum logic [3:0] {
        S_IDLE,
        S_VDT,     // mul vel*dt; add motor+drag force
        S_ADT,     // mul acc*dt; predicted position
        S_FMASS,   // mul force sum*inv_mass; predicted velocity
        S_DRPM,    // mul da*speed_to_rpm; position residual
        S_KPOS,    // mul position gain; predicted rpm
        S_UPOS,    // mul motor force gain; update position
        S_EVEL,    // mul drag force gain; velocity residual
        S_EACC,    // mul velocity gain; acceleration residual
        S_UVEL,    // mul accel gain; update velocity
        S_UACC,    // update acceleration
        S_ERPM,    // rpm residual
        S_KRPM,    // mul rpm gain
        S_URPM,    // update rpm
        S_OUT
    } t_state;

    t_state r_state;

    // Configuration registers
    cgse_pkg::t_q16                       r_gain_pos;
    cgse_pkg::t_q16                       r_gain_vel;
    cgse_pkg::t_q16                       r_gain_acc;
    cgse_pkg::t_q16                       r_gain_fm;
    cgse_pkg::t_q16                       r_gain_fd;
    cgse_pkg::t_q16                       r_gain_rpm;
    logic [cgse_pkg::InvMassW-1:0]        r_inv_mass;
    cgse_pkg::t_q16                       r_s2r;

    // Estimates
    cgse_pkg::t_q16 r_est_pos, r_est_vel, r_est_acc, r_est_fm, r_est_fd, r_est_rpm;

    // Captured item
    logic [cgse_pkg::StepW-1:0] r_dt;
    cgse_pkg::t_q16 r_m_pos, r_m_vel, r_m_acc, r_m_fm, r_m_fd, r_m_rpm;

    // Working registers
    cgse_pkg::t_q16 r_fsum, r_da, r_pp, r_pv, r_pa, r_pr, r_e, r_e2;
    cgse_pkg::t_prod r_prod;

    // Shared unit operands
    cgse_pkg::t_q16 mul_a, mul_b;
    cgse_pkg::t_q16 add_x, add_y;
    logic           add_neg;
    cgse_pkg::t_sum add_raw;
    cgse_pkg::t_q16 add_res;
    cgse_pkg::t_q16 q;
    cgse_pkg::t_q16 dt_op;
    cgse_pkg::t_q16 inv_op;

    assign dt_op  = $signed({{(cgse_pkg::DataW-cgse_pkg::StepW){1'b0}}, r_dt});
    assign inv_op = $signed({{(cgse_pkg::DataW-cgse_pkg::InvMassW){1'b0}}, r_inv_mass});

    // Scaled, clamped product of the previous step
    assign q = cgse_pkg::sat_prod(r_prod);

    // Operand selection for the multiplier and the adder
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        add_x   = '0;
        add_y   = '0;
        add_neg = 1'b0;
        case (r_state)
            S_VDT: begin
                mul_a = r_est_vel;  mul_b = dt_op;
                add_x = r_est_fm;   add_y = r_est_fd;
            end
            S_ADT: begin
                mul_a = r_est_acc;  mul_b = dt_op;
                add_x = r_est_pos;  add_y = q;
            end
            S_FMASS: begin
                mul_a = r_fsum;     mul_b = inv_op;
                add_x = r_est_vel;  add_y = q;
            end
            S_DRPM: begin
                mul_a = r_da;       mul_b = r_s2r;
                add_x = r_m_pos;    add_y = r_pp;  add_neg = 1'b1;
            end
            S_KPOS: begin
                mul_a = r_gain_pos; mul_b = r_e;
                add_x = r_est_rpm;  add_y = q;
            end
            S_UPOS: begin
                mul_a = r_gain_fm;  mul_b = r_m_fm;
                add_x = r_pp;       add_y = q;
            end
            S_EVEL: begin
                mul_a = r_gain_fd;  mul_b = r_m_fd;
                add_x = r_m_vel;    add_y = r_pv;  add_neg = 1'b1;
            end
            S_EACC: begin
                mul_a = r_gain_vel; mul_b = r_e;
                add_x = r_m_acc;    add_y = r_pa;  add_neg = 1'b1;
            end
            S_UVEL: begin
                mul_a = r_gain_acc; mul_b = r_e2;
                add_x = r_pv;       add_y = q;
            end
            S_UACC: begin
                add_x = r_pa;       add_y = q;
            end
            S_ERPM: begin
                add_x = r_m_rpm;    add_y = r_pr;  add_neg = 1'b1;
            end
            S_KRPM: begin
                mul_a = r_gain_rpm; mul_b = r_e;
            end
            S_URPM: begin
                add_x = r_pr;       add_y = q;
            end
            default: begin
            end
        endcase
    end

    // Saturating adder: widen by two bits so that a difference never wraps
    always_comb begin
        if (add_neg) begin
            add_raw = cgse_pkg::t_sum'(add_x) - cgse_pkg::t_sum'(add_y);
        end else begin
            add_raw = cgse_pkg::t_sum'(add_x) + cgse_pkg::t_sum'(add_y);
        end
        add_res = cgse_pkg::sat_sum(add_raw);
    end

    // Configuration writes; all eight indexes are in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_pos <= '0;
            r_gain_vel <= '0;
            r_gain_acc <= '0;
            r_gain_fm  <= '0;
            r_gain_fd  <= '0;
            r_gain_rpm <= '0;
            r_inv_mass <= cgse_pkg::InvMassReset;
            r_s2r      <= cgse_pkg::SpeedToRpmReset;
        end else if (i_cfg_we) begin
            case (cgse_pkg::t_reg_idx'(i_cfg_idx))
                cgse_pkg::REG_GAIN_POSITION:    r_gain_pos <= i_cfg_data;
                cgse_pkg::REG_GAIN_VELOCITY:    r_gain_vel <= i_cfg_data;
                cgse_pkg::REG_GAIN_ACCEL:       r_gain_acc <= i_cfg_data;
                cgse_pkg::REG_GAIN_MOTOR_FORCE: r_gain_fm  <= i_cfg_data;
                cgse_pkg::REG_GAIN_DRAG_FORCE:  r_gain_fd  <= i_cfg_data;
                cgse_pkg::REG_GAIN_RPM:         r_gain_rpm <= i_cfg_data;
                cgse_pkg::REG_INV_MASS:
                    r_inv_mass <= i_cfg_data[cgse_pkg::InvMassW-1:0];
                cgse_pkg::REG_SPEED_TO_RPM:     r_s2r      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer, working registers and estimates
    always_ff @(posedge i_clk) begin
        // Keep the multiplier busy every cycle; only the next step reads it
        r_prod <= cgse_pkg::t_prod'(mul_a) * cgse_pkg::t_prod'(mul_b);
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_est_pos <= '0;
            r_est_vel <= '0;
            r_est_acc <= '0;
            r_est_fm  <= '0;
            r_est_fd  <= '0;
            r_est_rpm <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_meas.valid) begin
                        // Capture the item and start the sequence
                        r_dt    <= i_meas.time_step;
                        r_m_pos <= i_meas.meas_position;
                        r_m_vel <= i_meas.meas_velocity;
                        r_m_acc <= i_meas.meas_accel;
                        r_m_fm  <= i_meas.meas_motor_force;
                        r_m_fd  <= i_meas.meas_drag_force;
                        r_m_rpm <= i_meas.meas_rpm;
                        r_state <= S_VDT;
                    end
                end
                S_VDT: begin
                    r_fsum  <= add_res;
                    r_state <= S_ADT;
                end
                S_ADT: begin
                    r_pp    <= add_res;
                    r_state <= S_FMASS;
                end
                S_FMASS: begin
                    r_da    <= q;
                    r_pv    <= add_res;
                    r_state <= S_DRPM;
                end
                S_DRPM: begin
                    r_pa    <= q;
                    r_e     <= add_res;
                    r_state <= S_KPOS;
                end
                S_KPOS: begin
                    r_pr    <= add_res;
                    r_state <= S_UPOS;
                end
                S_UPOS: begin
                    r_est_pos <= add_res;
                    r_state   <= S_EVEL;
                end
                S_EVEL: begin
                    // Predicted motor force is zero: the scaled product is the update
                    r_est_fm <= q;
                    r_e      <= add_res;
                    r_state  <= S_EACC;
                end
                S_EACC: begin
                    r_est_fd <= q;
                    r_e2     <= add_res;
                    r_state  <= S_UVEL;
                end
                S_UVEL: begin
                    r_est_vel <= add_res;
                    r_state   <= S_UACC;
                end
                S_UACC: begin
                    r_est_acc <= add_res;
                    r_state   <= S_ERPM;
                end
                S_ERPM: begin
                    r_e     <= add_res;
                    r_state <= S_KRPM;
                end
                S_KRPM: begin
                    r_state <= S_URPM;
                end
                S_URPM: begin
                    r_est_rpm <= add_res;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    // Hold the result item until the sink takes it
                    if (o_est.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_meas.ready          = (r_state == S_IDLE);
    assign o_est.valid           = (r_state == S_OUT);
    assign o_est.out_position    = r_est_pos;
    assign o_est.out_velocity    = r_est_vel;
    assign o_est.out_accel       = r_est_acc;
    assign o_est.out_motor_force = r_est_fm;
    assign o_est.out_drag_force  = r_est_fd;
    assign o_est.out_rpm         = r_est_rpm;

endmodule

// ===== design/cgse_chk.sv =====
// ----------------------------------------------------------------------------
// cgse_chk: port-level checks for the state estimator core
// Watches the two channels over time; attached to the core by bind.
// ----------------------------------------------------------------------------
module cgse_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [cgse_pkg::DataW-1:0]  i_out_position,
    input logic [cgse_pkg::DataW-1:0]  i_out_rpm
);

    // One item at a time: never take an item while a result is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while result item is shown");

    // After an item is taken, stop taking items
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready stayed high after an item was taken");

    // Reset leaves the block ready and showing nothing
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("block not idle after reset");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_position) && $stable(i_out_rpm)))
        else $error("stalled result item changed");

endmodule

bind constant_gain_state_estimator_core cgse_chk u_cgse_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_meas.valid),
    .i_in_ready     (i_meas.ready),
    .i_out_valid    (o_est.valid),
    .i_out_ready    (o_est.ready),
    .i_out_position (o_est.out_position),
    .i_out_rpm      (o_est.out_rpm)
);
